/* src/nhr_pkg.sv */
// Package for the NRZI HDLC frame receiver: payload structs, sizing constants,
// status codes and the CRC-16 octet update. No dependencies.
package nhr_pkg;

  localparam int MAX_FRAME_BITS   = 1024;
  localparam int STUFF_AFTER_ONES = 5;
  localparam int FLAG_ONES        = STUFF_AFTER_ONES + 1;
  localparam int OCTET_BITS       = 8;
  localparam int FCS_OCTETS       = 2;

  // Kept bit counter holds MAX_FRAME_BITS + 1 at most
  localparam int KEPT_W        = $clog2(MAX_FRAME_BITS + 2);
  // Octet leaves the window once a flag's leading zero and its ones follow it
  localparam int RECENT_W      = FLAG_ONES + 1 + OCTET_BITS;
  localparam int FIRST_RELEASE = RECENT_W;
  localparam int CRC_START     = FIRST_RELEASE + FCS_OCTETS * OCTET_BITS;

  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;

  localparam logic [2:0] ST_GOOD       = 3'd0;
  localparam logic [2:0] ST_FCS_BAD    = 3'd1;
  localparam logic [2:0] ST_SHORT      = 3'd2;
  localparam logic [2:0] ST_SEVEN_ONES = 3'd3;
  localparam logic [2:0] ST_TOO_LONG   = 3'd4;

  localparam logic KIND_BIT   = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam int         MIN_W         = 7;
  localparam logic [6:0] MIN_MSG_RESET = 7'd4;
  localparam int         CFG_AW        = 3;
  localparam int         CFG_DW        = 32;
  localparam logic       REG_MIN_MSG   = 1'b0;

  localparam int TOK_DEPTH = 4;
  localparam int TOK_AW    = $clog2(TOK_DEPTH);
  localparam int RES_DEPTH = 2;

  typedef struct packed {
    logic kind;
    logic line_level;
  } nhr_in_t;

  typedef struct packed {
    logic       is_end;
    logic [7:0] data_octet;
    logic [2:0] frame_status;
    logic [7:0] octet_count;
  } nhr_out_t;

  typedef struct packed {
    logic is_start;
    logic bit_val;
  } nhr_tok_t;

  function automatic logic [15:0] crc_octet(input logic [15:0] crc, input logic [7:0] octet);
    logic [15:0] c;
    int          i;
    c = crc ^ {8'h00, octet};
    for (i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Whole octets in a bit count, low 8 bits
  function automatic logic [7:0] octet_count_of(input logic [KEPT_W-1:0] bits);
    logic [KEPT_W+7:0] w;
    w = {8'h00, bits};
    return w[10:3];
  endfunction

endpackage

/* src/nhr_front.sv */
// Front end: accepts input beats and turns line levels into NRZI-decoded tokens.
// Depends on nhr_pkg; feeds nhr_tok_queue.
module nhr_front import nhr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  nhr_in_t  in_data,
  output logic     in_full,
  input  logic     q_full,
  output logic     q_wr,
  output nhr_tok_t q_tok
);

  logic last_level_r, last_level_nxt;

  assign in_full = q_full;
  assign q_wr    = in_push && !q_full;

  always_comb begin
    q_tok.is_start = (in_data.kind == KIND_START);
    // unchanged level decodes as a one
    q_tok.bit_val  = (in_data.kind == KIND_BIT) && (in_data.line_level == last_level_r);
    last_level_nxt = q_wr ? in_data.line_level : last_level_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b0;
    end else begin
      last_level_r <= last_level_nxt;
    end
  end

endmodule

/* src/nhr_tok_queue.sv */
// Short token queue between front and back end.
// Depends on nhr_pkg.
module nhr_tok_queue import nhr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  nhr_tok_t wr_tok,
  output logic     full,
  input  logic     rd_en,
  output nhr_tok_t rd_tok,
  output logic     empty
);

  nhr_tok_t            mem_r [TOK_DEPTH];
  logic [TOK_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [TOK_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [TOK_AW:0]     cnt_r, cnt_nxt;

  assign full   = (cnt_r == (TOK_AW + 1)'(TOK_DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_tok = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* src/nhr_back.sv */
// Back end: destuffing, flag and abort detection, octet release, CRC-16 check,
// and the two-entry result queue. Depends on nhr_pkg.
module nhr_back import nhr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [MIN_W-1:0] min_msg,
  input  logic             tok_valid,
  input  nhr_tok_t         tok,
  output logic             tok_rd,
  output logic             out_empty,
  input  logic             out_pop,
  output nhr_out_t         out_data
);

  localparam logic [2:0]        STUFF_K = 3'(STUFF_AFTER_ONES);
  localparam logic [2:0]        FLAG_K  = 3'(FLAG_ONES);
  localparam logic [KEPT_W-1:0] MAX_K   = KEPT_W'(MAX_FRAME_BITS);
  localparam logic [KEPT_W-1:0] FIRST_K = KEPT_W'(FIRST_RELEASE);
  localparam logic [KEPT_W-1:0] CRC_K   = KEPT_W'(CRC_START);

  logic                burst_r, burst_nxt;
  logic [2:0]          ones_r, ones_nxt;
  logic [KEPT_W-1:0]   kept_r, kept_nxt;
  logic [KEPT_W-1:0]   run_begin_r, run_begin_nxt;
  logic [RECENT_W-1:0] recent_r, recent_nxt;
  logic [15:0]         crc_r, crc_nxt;
  logic [7:0]          held0_r, held0_nxt;
  logic [7:0]          held1_r, held1_nxt;

  nhr_out_t            res_mem_r [RES_DEPTH];
  logic                res_wr_r, res_rd_r;
  logic [1:0]          res_cnt_r, res_cnt_nxt;
  logic                res_full, res_push, res_pop;
  nhr_out_t            res;

  logic                do_push, do_clear;
  logic                end_hit;
  logic [2:0]          end_st;
  logic [KEPT_W-1:0]   end_bits;
  logic [KEPT_W-1:0]   kept_inc, len;
  logic [RECENT_W-1:0] recent_sh;
  logic [KEPT_W+7:0]   n_w, need_w;

  assign res_full  = (res_cnt_r == 2'(RES_DEPTH));
  assign out_empty = (res_cnt_r == '0);
  assign res_pop   = out_pop && !out_empty;
  assign tok_rd    = tok_valid && !res_full;
  assign out_data  = res_mem_r[res_rd_r];

  always_comb begin
    burst_nxt     = burst_r;
    ones_nxt      = ones_r;
    kept_nxt      = kept_r;
    run_begin_nxt = run_begin_r;
    recent_nxt    = recent_r;
    crc_nxt       = crc_r;
    held0_nxt     = held0_r;
    held1_nxt     = held1_r;
    res_push      = 1'b0;
    res           = '0;
    do_push       = 1'b0;
    do_clear      = 1'b0;
    end_hit       = 1'b0;
    end_st        = ST_GOOD;
    end_bits      = '0;

    kept_inc  = kept_r + 1'b1;
    recent_sh = {tok.bit_val, recent_r[RECENT_W-1:1]};
    // frame length drops the flag's leading zero
    len       = (run_begin_r != '0) ? run_begin_r - 1'b1 : '0;
    n_w       = (KEPT_W + 8)'(len >> 3);
    need_w    = (KEPT_W + 8)'(min_msg) + (KEPT_W + 8)'(FCS_OCTETS);

    if (tok_rd) begin
      if (tok.is_start) begin
        do_clear  = 1'b1;
        burst_nxt = 1'b1;
      end else if (burst_r) begin
        if (tok.bit_val) begin
          ones_nxt = ones_r + 1'b1;
          if (ones_r == FLAG_K) begin
            end_hit  = 1'b1;
            end_st   = ST_SEVEN_ONES;
            end_bits = kept_r;
          end else begin
            do_push = 1'b1;
          end
        end else begin
          ones_nxt = '0;
          if (ones_r == FLAG_K) begin
            if (len == '0) begin
              // empty frame right after a flag: keep reading the burst
              do_clear = 1'b1;
            end else if (len[2:0] != 3'd0 || n_w < need_w) begin
              end_hit  = 1'b1;
              end_st   = ST_SHORT;
              end_bits = len;
            end else begin
              end_hit  = 1'b1;
              end_st   = ((crc_r ^ CRC_PRESET) == {held1_r, held0_r}) ? ST_GOOD : ST_FCS_BAD;
              end_bits = len;
            end
          end else if (ones_r == STUFF_K) begin
            // drop the stuffed zero
            run_begin_nxt = kept_r;
          end else begin
            do_push       = 1'b1;
            run_begin_nxt = kept_inc;
          end
        end
      end
    end

    if (do_push) begin
      recent_nxt = recent_sh;
      kept_nxt   = kept_inc;
      if (kept_inc > MAX_K) begin
        end_hit  = 1'b1;
        end_st   = ST_TOO_LONG;
        end_bits = kept_inc;
      end else if (kept_inc >= FIRST_K && kept_inc[2:0] == FIRST_K[2:0]) begin
        if (kept_inc >= CRC_K) begin
          crc_nxt = crc_octet(crc_r, held0_r);
        end
        held0_nxt      = held1_r;
        held1_nxt      = recent_sh[7:0];
        res_push       = 1'b1;
        res.data_octet = recent_sh[7:0];
      end
    end

    if (end_hit) begin
      burst_nxt        = 1'b0;
      res_push         = 1'b1;
      res.is_end       = 1'b1;
      res.data_octet   = '0;
      res.frame_status = end_st;
      res.octet_count  = octet_count_of(end_bits);
    end

    if (do_clear) begin
      ones_nxt      = '0;
      kept_nxt      = '0;
      run_begin_nxt = '0;
      recent_nxt    = '0;
      crc_nxt       = CRC_PRESET;
      held0_nxt     = '0;
      held1_nxt     = '0;
    end

    res_cnt_nxt = res_cnt_r;
    if (res_push && !res_pop) begin
      res_cnt_nxt = res_cnt_r + 1'b1;
    end else if (res_pop && !res_push) begin
      res_cnt_nxt = res_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem_r[res_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r     <= 1'b0;
      ones_r      <= '0;
      kept_r      <= '0;
      run_begin_r <= '0;
      recent_r    <= '0;
      crc_r       <= CRC_PRESET;
      held0_r     <= '0;
      held1_r     <= '0;
      res_wr_r    <= 1'b0;
      res_rd_r    <= 1'b0;
      res_cnt_r   <= '0;
    end else begin
      burst_r     <= burst_nxt;
      ones_r      <= ones_nxt;
      kept_r      <= kept_nxt;
      run_begin_r <= run_begin_nxt;
      recent_r    <= recent_nxt;
      crc_r       <= crc_nxt;
      held0_r     <= held0_nxt;
      held1_r     <= held1_nxt;
      res_wr_r    <= res_push ? ~res_wr_r : res_wr_r;
      res_rd_r    <= res_pop ? ~res_rd_r : res_rd_r;
      res_cnt_r   <= res_cnt_nxt;
    end
  end

endmodule

/* src/nrzi_hdlc_frame_receiver.sv */
// NRZI HDLC frame receiver top level: configuration register, front end,
// token queue and back end. Depends on nhr_pkg, nhr_front, nhr_tok_queue, nhr_back.
//
// Usage:
//   Input queue port (in_push/in_full/in_data): one beat per line reading, kind 0,
//   or a burst-start mark, kind 1, from the sync detector. A beat is taken on any
//   edge with in_push high and in_full low.
//   Result queue port (out_empty/out_pop/out_data): released data octets and one
//   end-of-frame status per frame, oldest first while out_empty is low.
//   APB port: register 0 at byte address 0 holds min_message_octets (reset 4).
//   Throughput: one beat per cycle while the result queue is not full, set by
//   the back end's bit step (destuff, octet release and CRC-16 octet update).
//   Reset empties both queues and leaves the block idle until a burst start.
//   When the result side stalls, the two-entry result queue fills, the back end
//   holds, the four-entry token queue fills behind it and in_full rises.
module nrzi_hdlc_frame_receiver import nhr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  nhr_in_t           in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output nhr_out_t          out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [MIN_W-1:0] min_msg_r, min_msg_nxt;
  logic             cfg_wr;
  logic             q_full, q_wr, q_rd, q_empty;
  nhr_tok_t         q_wr_tok, q_rd_tok;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[CFG_AW-1:2] == REG_MIN_MSG);
  assign min_msg_nxt = cfg_wr ? cfg_pwdata[MIN_W-1:0] : min_msg_r;
  assign cfg_prdata  = (cfg_paddr[CFG_AW-1:2] == REG_MIN_MSG) ? CFG_DW'(min_msg_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_msg_r <= MIN_MSG_RESET;
    end else begin
      min_msg_r <= min_msg_nxt;
    end
  end

  nhr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_tok   (q_wr_tok)
  );

  nhr_tok_queue u_tok_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_wr),
    .wr_tok (q_wr_tok),
    .full   (q_full),
    .rd_en  (q_rd),
    .rd_tok (q_rd_tok),
    .empty  (q_empty)
  );

  nhr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .min_msg   (min_msg_r),
    .tok_valid (!q_empty),
    .tok       (q_rd_tok),
    .tok_rd    (q_rd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

/* src/nhr_checker.sv */
// Port-level checks for the NRZI HDLC frame receiver, bound to the top level.
// Depends on nhr_pkg and nrzi_hdlc_frame_receiver.
module nhr_checker import nhr_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_full,
  input logic     out_empty,
  input logic     out_pop,
  input nhr_out_t out_data
);

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result waiting after reset");

  // input side backs up only behind a waiting result
  a_full_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("input full with no result waiting");

  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.is_end) |->
      (out_data.frame_status == ST_GOOD && out_data.octet_count == 8'd0))
    else $error("data beat carries status or count");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.is_end) |->
      (out_data.data_octet == 8'd0 && out_data.frame_status <= ST_TOO_LONG))
    else $error("bad end-of-frame beat");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed before pop");

endmodule

bind nrzi_hdlc_frame_receiver nhr_checker u_nhr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
